### rtl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Entry layout, operation codes and status codes shared by the heap block.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 8;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 7;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]    payload;
   } entry_type;

   localparam kind_type KIND_INSERT = 2'd0;
   localparam kind_type KIND_POLL   = 2'd1;
   localparam kind_type KIND_CLEAR  = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

### rtl/bhpq_ram.sv
// ----------------------------------------------------------------------------
// Heap entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_ram #(
   parameter int DEPTH = 64
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire bhpq_pkg::entry_type       wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output bhpq_pkg::entry_type            rd_data
);

   bhpq_pkg::entry_type mem [DEPTH];
   bhpq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/bhpq_order.sv
// ----------------------------------------------------------------------------
// Heap order comparator
// Tells whether entry a must sit above entry b; equal keys never qualify.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_order (
   input  wire logic                 max_first,
   input  wire bhpq_pkg::entry_type  a,
   input  wire bhpq_pkg::entry_type  b,
   output logic                      a_first
);

   always_comb begin
      if (max_first) begin
         a_first = ($signed(a.key) > $signed(b.key));
      end else begin
         a_first = ($signed(a.key) < $signed(b.key));
      end
   end

endmodule

`default_nettype wire

### rtl/binary_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Fixed-depth array heap of key and payload entries, min-first or max-first.
// ----------------------------------------------------------------------------
// Usage:
// A request word on req_ carries an operation (insert, poll root, clear) with
// a key and payload for inserts. Every request yields exactly one response
// word on rsp_ with a status, the polled key and payload, and the entry count.
// The csr_ channel writes the order bit and must only be used while idle.
// Clear, unused codes, an empty poll and a full insert are answered straight
// from idle. An insert reads the parent and compares for each heap level it
// climbs, and writes the entry once, at the root or below the first parent
// that it does not beat. A poll reads the root and then the last entry, loads
// it, and for each level descended reads the left child, compares, reads the
// right child and compares again, until the entry sinks to a leaf or settles
// above its children. The single read port of the entry store and the one
// shared comparator set these steps. One operation runs at a time; req_ready is
// low while it runs, and also while a finished response waits and the receiver
// holds rsp_ready low. Reset empties the heap and selects min-first order;
// stored entries are not cleared and are never read before an insert writes them.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue_core #(
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic [bhpq_pkg::KIND_W-1:0]             req_kind,
   input  wire logic signed [bhpq_pkg::KEY_W-1:0]       req_key,
   input  wire logic [bhpq_pkg::PAYLOAD_W-1:0]          req_payload,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic [bhpq_pkg::STATUS_W-1:0]                rsp_status,
   output logic signed [bhpq_pkg::KEY_W-1:0]            rsp_out_key,
   output logic [bhpq_pkg::PAYLOAD_W-1:0]               rsp_out_payload,
   output logic [bhpq_pkg::COUNT_W-1:0]                 rsp_count,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic                                    csr_max_first
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = ADDR_W + 2;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_UP_RD  = 4'd1;
   localparam logic [3:0] S_UP_CMP = 4'd2;
   localparam logic [3:0] S_P_ROOT = 4'd3;
   localparam logic [3:0] S_P_LAST = 4'd4;
   localparam logic [3:0] S_P_LOAD = 4'd5;
   localparam logic [3:0] S_DN_L   = 4'd6;
   localparam logic [3:0] S_DN_R   = 4'd7;
   localparam logic [3:0] S_DN_CMP = 4'd8;

   logic [3:0]                        state_ff, state_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              max_first_ff, max_first_in;
   logic [ADDR_W-1:0]                 pos_ff, pos_in;
   bhpq_pkg::entry_type               entry_ff, entry_in;
   bhpq_pkg::entry_type               best_ff, best_in;
   logic                              left_win_ff, left_win_in;
   logic                              r_ok_ff, r_ok_in;
   bhpq_pkg::status_type              status_ff, status_in;
   logic signed [bhpq_pkg::KEY_W-1:0] key_ff, key_in;
   logic [bhpq_pkg::PAYLOAD_W-1:0]    pay_ff, pay_in;
   logic [bhpq_pkg::COUNT_W-1:0]      cnt_out_ff, cnt_out_in;

   logic                              req_fire;
   logic                              finish;
   logic                              mem_wr_en;
   logic [ADDR_W-1:0]                 mem_wr_addr;
   bhpq_pkg::entry_type               mem_wr_data;
   logic                              mem_rd_en;
   logic [ADDR_W-1:0]                 mem_rd_addr;
   bhpq_pkg::entry_type               mem_rd_data;
   bhpq_pkg::entry_type               cmp_a, cmp_b;
   logic                              a_first;
   logic [ADDR_W-1:0]                 pos_m1, parent;
   logic [IDX_W-1:0]                  l_wide, r_wide, n_wide;
   logic [ADDR_W-1:0]                 l_addr, r_addr;

   bhpq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bhpq_order u_order (
      .max_first (max_first_ff),
      .a         (cmp_a),
      .b         (cmp_b),
      .a_first   (a_first)
   );

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign pos_m1 = pos_ff - 1'b1;
   assign parent = pos_m1 >> 1;
   assign l_wide = {1'b0, pos_ff, 1'b1};
   assign r_wide = l_wide + 1'b1;
   assign n_wide = IDX_W'(count_ff);
   assign l_addr = l_wide[ADDR_W-1:0];
   assign r_addr = r_wide[ADDR_W-1:0];

   assign max_first_in = (csr_valid && csr_ready) ? csr_max_first : max_first_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      entry_in     = entry_ff;
      best_in      = best_ff;
      left_win_in  = left_win_ff;
      r_ok_in      = r_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      cnt_out_in   = cnt_out_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pos_ff;
      mem_wr_data  = entry_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      cmp_a        = entry_ff;
      cmp_b        = mem_rd_data;
      finish       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               status_in = bhpq_pkg::STATUS_OK;
               key_in    = '0;
               pay_in    = '0;
               case (req_kind)
                  bhpq_pkg::KIND_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = bhpq_pkg::STATUS_FULL;
                        finish    = 1'b1;
                     end else begin
                        entry_in.key     = req_key;
                        entry_in.payload = req_payload;
                        pos_in           = ADDR_W'(count_ff);
                        count_in         = count_ff + 1'b1;
                        state_in         = S_UP_RD;
                     end
                  end
                  bhpq_pkg::KIND_POLL: begin
                     if (count_ff == '0) begin
                        status_in = bhpq_pkg::STATUS_EMPTY;
                        finish    = 1'b1;
                     end else begin
                        count_in = count_ff - 1'b1;
                        state_in = S_P_ROOT;
                     end
                  end
                  bhpq_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     finish   = 1'b1;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end

         // The new entry rides in a register while parents move down into
         // the hole; it is written once, where the climb stops.
         S_UP_RD: begin
            if (pos_ff == '0) begin
               mem_wr_en = 1'b1;
               finish    = 1'b1;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = parent;
               state_in    = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            cmp_a = entry_ff;
            cmp_b = mem_rd_data;
            if (a_first) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = mem_rd_data;
               pos_in      = parent;
               state_in    = S_UP_RD;
            end else begin
               mem_wr_en = 1'b1;
               finish    = 1'b1;
            end
         end

         S_P_ROOT: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_in    = S_P_LAST;
         end

         // The count has already been decremented, so it indexes the last entry.
         S_P_LAST: begin
            key_in      = mem_rd_data.key;
            pay_in      = mem_rd_data.payload;
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(count_ff);
            state_in    = S_P_LOAD;
         end

         S_P_LOAD: begin
            entry_in = mem_rd_data;
            pos_in   = '0;
            state_in = S_DN_L;
         end

         S_DN_L: begin
            if (l_wide >= n_wide) begin
               mem_wr_en = 1'b1;
               finish    = 1'b1;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = l_addr;
               state_in    = S_DN_R;
            end
         end

         S_DN_R: begin
            cmp_a       = mem_rd_data;
            cmp_b       = entry_ff;
            left_win_in = a_first;
            best_in     = a_first ? mem_rd_data : entry_ff;
            r_ok_in     = (r_wide < n_wide);
            if (r_wide < n_wide) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = r_addr;
            end
            state_in = S_DN_CMP;
         end

         // The right child must beat the better of the moving entry and the
         // left child; otherwise the left child wins, or the entry settles.
         S_DN_CMP: begin
            cmp_a = mem_rd_data;
            cmp_b = best_ff;
            if (r_ok_ff && a_first) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = mem_rd_data;
               pos_in      = r_addr;
               state_in    = S_DN_L;
            end else if (left_win_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = best_ff;
               pos_in      = l_addr;
               state_in    = S_DN_L;
            end else begin
               mem_wr_en = 1'b1;
               finish    = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         cnt_out_in   = bhpq_pkg::COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         max_first_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         max_first_ff <= max_first_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      entry_ff    <= entry_in;
      best_ff     <= best_in;
      left_win_ff <= left_win_in;
      r_ok_ff     <= r_ok_in;
      status_ff   <= status_in;
      key_ff      <= key_in;
      pay_ff      <= pay_in;
      cnt_out_ff  <= cnt_out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_key     = key_ff;
   assign rsp_out_payload = pay_ff;
   assign rsp_count       = cnt_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds heap depth");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response word pending while an operation is in progress");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == bhpq_pkg::KIND_INSERT && count_ff != CNT_W'(DEPTH))
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("accepted insert did not grow the heap by one");

   a_empty_poll: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == bhpq_pkg::KIND_POLL && count_ff == '0)
      |=> (rsp_valid_ff && status_ff == bhpq_pkg::STATUS_EMPTY))
      else $error("poll on empty heap not answered with empty status");

endmodule

`default_nettype wire
